FILE: src/life_grid_generation_step_defines.svh
// Assertion macros for the checker file.
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lgs_pkg.sv
// Types, constants and cell rule functions for the life grid block.
package lgs_pkg;

  localparam int CMD_W     = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NBR_W     = 4;

  localparam logic [CFG_W-1:0] RESET_ROWS    = 7'd40;
  localparam logic [CFG_W-1:0] RESET_COLUMNS = 7'd60;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 1'b1;

  localparam logic [NBR_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [NBR_W-1:0] NBR_MAX     = 4'd8;

  // phase counter values for the read and write sequences
  localparam logic [1:0] PH_WRITE_LAST = 2'd1;
  localparam logic [1:0] PH_READ_LAST  = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_STEP  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_STEP,
    ST_DONE
  } state_e;

  function automatic logic [NBR_W-1:0] nbr_count(input logic [2:0] above,
                                                 input logic [1:0] beside,
                                                 input logic [2:0] below);
    logic [7:0]       bits;
    logic [NBR_W-1:0] n;
    bits = {above, beside, below};
    n    = '0;
    for (int k = 0; k < 8; k++) begin
      n = n + NBR_W'(bits[k]);
    end
    return n;
  endfunction

  // B3/S23
  function automatic logic life_rule(input logic alive, input logic [NBR_W-1:0] n);
    logic nxt;
    if (alive) begin
      nxt = (n == SURVIVE_MIN) || (n == BIRTH_COUNT);
    end else begin
      nxt = (n == BIRTH_COUNT);
    end
    return nxt;
  endfunction

endpackage

FILE: src/lgs_req_if.sv
// Request channel: command, cell coordinates and write value.
interface lgs_req_if;
  import lgs_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;
  logic             alive_in;

  modport source (output valid, output cmd, output row, output column, output alive_in,
                  input ready);
  modport sink   (input valid, input cmd, input row, input column, input alive_in,
                  output ready);
endinterface

FILE: src/lgs_rsp_if.sv
// Response channel: cell state, neighbor count and status.
interface lgs_rsp_if;
  import lgs_pkg::*;

  logic             valid;
  logic             ready;
  logic             alive_out;
  logic [NBR_W-1:0] neighbours;
  logic             status;

  modport source (output valid, output alive_out, output neighbours, output status,
                  input ready);
  modport sink   (input valid, input alive_out, input neighbours, input status,
                  output ready);
endinterface

FILE: src/life_grid_generation_step.sv
// Game of life grid held in a row-wide memory, with cell access and generation step.
//
//   channel  dir  handshake         payload
//   req_i    in   valid/ready       cmd, row, column, alive_in
//   rsp_o    out  valid/ready       alive_out, neighbours, status
//   cfg      in   cfg_we_i          cfg_idx_i, cfg_data_i
//
// One request at a time, paced by the single read port of the row memory:
// a write reads its row and writes it back, a read takes three row reads,
// and a step reads one row and writes one row per cycle.
// After reset a clearing pass writes MAX_ROWS rows; req_i.ready stays low meanwhile.
// The response register lets the next request be taken while a result waits.
module life_grid_generation_step #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lgs_req_if.sink                        req_i,
  lgs_rsp_if.source                      rsp_o,
  input  logic                           cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lgs_pkg::CFG_W-1:0]      cfg_data_i
);
  import lgs_pkg::*;

  localparam int RAW   = $clog2(MAX_ROWS);
  localparam int CAW   = $clog2(MAX_COLUMNS);
  localparam int PW_R  = $clog2(MAX_ROWS + 2);
  localparam int PW    = (PW_R > CFG_W) ? PW_R : CFG_W;
  localparam int NCW_R = $clog2(MAX_COLUMNS + 1);
  localparam int NCW   = (NCW_R > CFG_W) ? NCW_R : CFG_W;
  localparam logic [PW-1:0] LAST_STEP = PW'(MAX_ROWS + 1);
  localparam logic [PW-1:0] LAST_ROW  = PW'(MAX_ROWS - 1);

  state_e state_q, state_d;

  logic [CFG_W-1:0] rows_q, cols_q;
  logic [PW-1:0]    rp_q;
  logic [1:0]       ph_q;
  logic             rd_ok_q;
  logic             out_valid_q;

  logic [COL_W-1:0] col_q;
  logic             alive_q;
  logic             res_alive_q, res_status_q;
  logic [NBR_W-1:0] res_nbr_q;
  logic             out_alive_q, out_status_q;
  logic [NBR_W-1:0] out_nbr_q;

  logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
  logic [MAX_COLUMNS-1:0] rd_data_q;
  logic [MAX_COLUMNS-1:0] up_q, mid_q;

  logic [PW-1:0]          nr;
  logic [NCW-1:0]         nc;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [CAW-1:0]         col_ix;
  logic                   in_range, rp_lt_nr;
  logic [PW-1:0]          wrow;

  logic [MAX_COLUMNS-1:0] in_row, next_row, rmw_row;
  logic [MAX_COLUMNS+1:0] pad_up, pad_mid, pad_in;
  logic [NBR_W-1:0]       nbr_vec [MAX_COLUMNS];

  logic                   mem_re, mem_we, shift_en, rd_done, out_load;
  logic [RAW-1:0]         waddr;
  logic [MAX_COLUMNS-1:0] wdata;

  // size in use, clamped to the physical grid
  assign nr = (PW'(rows_q) > PW'(MAX_ROWS)) ? PW'(MAX_ROWS) : PW'(rows_q);
  assign nc = (NCW'(cols_q) > NCW'(MAX_COLUMNS)) ? NCW'(MAX_COLUMNS) : NCW'(cols_q);

  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      col_mask[j] = NCW'(j) < nc;
    end
  end

  assign in_range = (PW'(req_i.row) < nr) && (NCW'(req_i.column) < nc);
  assign rp_lt_nr = rp_q < nr;
  assign col_ix   = CAW'(col_q);
  assign wrow     = rp_q - PW'(2);

  // row arriving from memory; rows out of use and stale columns read as dead
  assign in_row = rd_ok_q ? (rd_data_q & col_mask) : '0;

  assign pad_up  = {1'b0, up_q, 1'b0};
  assign pad_mid = {1'b0, mid_q, 1'b0};
  assign pad_in  = {1'b0, in_row, 1'b0};

  // one lane per column, centered on the middle row of the window
  always_comb begin
    for (int j = 0; j < MAX_COLUMNS; j++) begin
      nbr_vec[j]  = nbr_count(pad_up[j +: 3], {pad_mid[j + 2], pad_mid[j]}, pad_in[j +: 3]);
      next_row[j] = life_rule(mid_q[j], nbr_vec[j]);
    end
  end

  always_comb begin
    rmw_row         = rd_data_q;
    rmw_row[col_ix] = alive_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (rp_q == LAST_ROW) state_d = ST_IDLE;
      ST_IDLE: begin
        if (req_i.valid) begin
          unique case (req_i.cmd)
            CMD_WRITE: state_d = in_range ? ST_WRITE : ST_DONE;
            CMD_READ:  state_d = in_range ? ST_READ : ST_DONE;
            CMD_STEP:  state_d = ST_STEP;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_WRITE: if (ph_q == PH_WRITE_LAST) state_d = ST_DONE;
      ST_READ:  if (ph_q == PH_READ_LAST) state_d = ST_DONE;
      ST_STEP:  if (rp_q == LAST_STEP) state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || rsp_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req_i.ready = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    shift_en    = 1'b0;
    rd_done     = 1'b0;
    out_load    = 1'b0;
    waddr       = rp_q[RAW-1:0];
    wdata       = '0;
    unique case (state_q)
      ST_CLEAR: mem_we = 1'b1;
      ST_IDLE:  req_i.ready = 1'b1;
      ST_WRITE: begin
        if (ph_q == PH_WRITE_LAST) begin
          mem_we = 1'b1;
          wdata  = rmw_row;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_READ: begin
        shift_en = 1'b1;
        mem_re   = (ph_q != PH_READ_LAST) && rp_lt_nr;
        rd_done  = ph_q == PH_READ_LAST;
      end
      ST_STEP: begin
        // row rp is read while row rp-2 is written; they never collide
        shift_en = 1'b1;
        mem_re   = rp_lt_nr;
        if (rp_q >= PW'(2)) begin
          mem_we = 1'b1;
          waddr  = wrow[RAW-1:0];
          wdata  = (wrow < nr) ? (next_row & col_mask) : '0;
        end
      end
      ST_DONE:  out_load = !out_valid_q || rsp_o.ready;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) grid_mem[waddr] <= wdata;
    if (mem_re) rd_data_q <= grid_mem[rp_q[RAW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rows_q      <= RESET_ROWS;
      cols_q      <= RESET_COLUMNS;
      rp_q        <= '0;
      ph_q        <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_ok_q <= mem_re;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ROWS:    rows_q <= cfg_data_i;
          CFG_COLUMNS: cols_q <= cfg_data_i;
          default:     ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          ph_q <= '0;
          if (req_i.cmd == CMD_READ) begin
            rp_q <= PW'(req_i.row) - PW'(1);
          end else if (req_i.cmd == CMD_WRITE) begin
            rp_q <= PW'(req_i.row);
          end else begin
            rp_q <= '0;
          end
        end
        ST_CLEAR, ST_STEP: rp_q <= rp_q + PW'(1);
        ST_READ: begin
          rp_q <= rp_q + PW'(1);
          ph_q <= ph_q + 2'd1;
        end
        ST_WRITE: ph_q <= ph_q + 2'd1;
        default:  ;
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      col_q        <= req_i.column;
      alive_q      <= req_i.alive_in;
      res_alive_q  <= 1'b0;
      res_nbr_q    <= '0;
      res_status_q <= ((req_i.cmd == CMD_WRITE) || (req_i.cmd == CMD_READ)) && !in_range;
    end
    if (rd_done) begin
      res_alive_q <= mid_q[col_ix];
      res_nbr_q   <= nbr_vec[col_ix];
    end
    if (shift_en) begin
      up_q  <= mid_q;
      mid_q <= in_row;
    end
    if (out_load) begin
      out_alive_q  <= res_alive_q;
      out_nbr_q    <= res_nbr_q;
      out_status_q <= res_status_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.alive_out  = out_alive_q;
  assign rsp_o.neighbours = out_nbr_q;
  assign rsp_o.status     = out_status_q;

endmodule

FILE: src/lgs_checker.sv
// Port-level checks for the life grid block, bound to the top level.
`include "life_grid_generation_step_defines.svh"

module lgs_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      rsp_valid_i,
  input logic                      rsp_ready_i,
  input logic                      alive_out_i,
  input logic [lgs_pkg::NBR_W-1:0] neighbours_i,
  input logic                      status_i
);
  import lgs_pkg::*;

  logic rsp_stall, in_take, flag_seen, data_clean, nbr_ok;

  assign rsp_stall  = rsp_valid_i && !rsp_ready_i;
  assign in_take    = in_valid_i && in_ready_i;
  assign flag_seen  = rsp_valid_i && status_i;
  assign data_clean = !alive_out_i && (neighbours_i == '0);
  assign nbr_ok     = neighbours_i <= NBR_MAX;

  // a pending response is held until taken
  `LGS_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i, "response dropped")

  // one request in flight: no accept in the cycle after an accept
  `LGS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_take, !in_ready_i, "taken while busy")

  // a flagged request reports no cell data
  `LGS_ASSERT_NOW(a_flag_clean, clk_i, rst_ni, flag_seen, data_clean, "flag with cell data")

  `LGS_ASSERT_NOW(a_nbr_range, clk_i, rst_ni, rsp_valid_i, nbr_ok, "neighbor count above eight")

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .alive_out_i  (rsp_o.alive_out),
  .neighbours_i (rsp_o.neighbours),
  .status_i     (rsp_o.status)
);

FILE: verif/tb_life_grid_generation_step.sv
// Self-checking testbench for the life grid block: cell writes, reads and generation steps.
module tb_life_grid_generation_step;
  import lgs_pkg::*;

  localparam int GRID_DIM = 64;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_PHASES = 9;
  localparam int PHASE_REQS = 100;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             alive_in;
  } life_req_t;

  typedef struct packed {
    logic             alive;
    logic [NBR_W-1:0] nbrs;
    logic             status;
  } cell_rsp_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  lgs_req_if req_if();
  lgs_rsp_if rsp_if();

  life_grid_generation_step #(
    .MAX_ROWS   (GRID_DIM),
    .MAX_COLUMNS(GRID_DIM)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_if),
    .rsp_o     (rsp_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // shadow grid and register copies
  bit               life_cells [GRID_DIM][GRID_DIM];
  bit               next_cells [GRID_DIM][GRID_DIM];
  logic [CFG_W-1:0] rows_cfg = RESET_ROWS;
  logic [CFG_W-1:0] cols_cfg = RESET_COLUMNS;

  life_req_t req_backlog[$];
  cell_rsp_t cell_answers[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_go = 1'b0;
  bit hold_on = 1'b0;
  int fail_count = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int span(logic [CFG_W-1:0] v);
    return (v > GRID_DIM) ? GRID_DIM : int'(v);
  endfunction

  function automatic int live_at(int r, int c);
    if (r < 0 || c < 0 || r >= span(rows_cfg) || c >= span(cols_cfg)) return 0;
    return life_cells[r][c];
  endfunction

  function automatic int live_nbrs(int r, int c);
    int n;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc);
      end
    end
    return n;
  endfunction

  // updates the shadow grid for one accepted request and queues its answer
  function automatic void apply_life_cmd(life_req_t rq);
    cell_rsp_t rsp;
    int        nr;
    int        nc;
    int        n;
    rsp = '0;
    nr  = span(rows_cfg);
    nc  = span(cols_cfg);
    if (rq.cmd == CMD_WRITE || rq.cmd == CMD_READ) begin
      if (rq.row >= nr || rq.column >= nc) begin
        rsp.status = 1'b1;
      end else if (rq.cmd == CMD_WRITE) begin
        life_cells[rq.row][rq.column] = rq.alive_in;
      end else begin
        rsp.alive = 1'(live_at(rq.row, rq.column));
        rsp.nbrs  = NBR_W'(live_nbrs(rq.row, rq.column));
      end
    end else if (rq.cmd == CMD_STEP) begin
      for (int i = 0; i < GRID_DIM; i++) begin
        for (int j = 0; j < GRID_DIM; j++) begin
          next_cells[i][j] = 1'b0;
          if (i < nr && j < nc) begin
            n = live_nbrs(i, j);
            next_cells[i][j] = life_cells[i][j] ? (n == SURVIVE_MIN || n == BIRTH_COUNT)
                                                : (n == BIRTH_COUNT);
          end
        end
      end
      life_cells = next_cells;
    end
    cell_answers.push_back(rsp);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    life_req_t nxt;
    if (!rst_ni) begin
      req_if.valid    <= 1'b0;
      req_if.cmd      <= CMD_WRITE;
      req_if.row      <= '0;
      req_if.column   <= '0;
      req_if.alive_in <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_life_cmd({req_if.cmd, req_if.row, req_if.column, req_if.alive_in});
      end
      if (!req_if.valid || req_if.ready) begin
        if (req_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = req_backlog.pop_front();
          req_if.valid    <= 1'b1;
          req_if.cmd      <= nxt.cmd;
          req_if.row      <= nxt.row;
          req_if.column   <= nxt.column;
          req_if.alive_in <= nxt.alive_in;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin
    cell_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (cell_answers.size() == 0) begin
          $display("%0t: unexpected response alive %0b nbrs %0d status %0b", $time,
                   rsp_if.alive_out, rsp_if.neighbours, rsp_if.status);
          fail_count++;
        end else begin
          want = cell_answers.pop_front();
          if (rsp_if.alive_out !== want.alive) begin
            $display("%0t: alive_out expected %0b got %0b", $time, want.alive,
                     rsp_if.alive_out);
            fail_count++;
          end
          if (rsp_if.neighbours !== want.nbrs) begin
            $display("%0t: neighbours expected %0d got %0d", $time, want.nbrs,
                     rsp_if.neighbours);
            fail_count++;
          end
          if (rsp_if.status !== want.status) begin
            $display("%0t: status expected %0b got %0b", $time, want.status,
                     rsp_if.status);
            fail_count++;
          end
        end
      end
      rsp_if.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off so the block backs up and stalls requests
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic set_grid(int rows, int cols);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_ROWS;
    cfg_data_i <= CFG_W'(rows);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_COLUMNS;
    cfg_data_i <= CFG_W'(cols);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    rows_cfg = CFG_W'(rows);
    cols_cfg = CFG_W'(cols);
  endtask

  task automatic queue_req(logic [CMD_W-1:0] cmd, int row, int col, bit alive);
    req_backlog.push_back({cmd, ROW_W'(row), COL_W'(col), alive});
  endtask

  task automatic drain();
    while (req_backlog.size() != 0 || req_if.valid || cell_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic life_req_t rand_req();
    life_req_t rq;
    int        roll;
    int        nr;
    int        nc;
    roll        = $urandom_range(99);
    nr          = span(rows_cfg);
    nc          = span(cols_cfg);
    rq.row      = ROW_W'($urandom_range(63));
    rq.column   = COL_W'($urandom_range(63));
    rq.alive_in = ($urandom_range(99) < 55);
    if (nr > 0 && nc > 0 && $urandom_range(9) != 0) begin
      rq.row    = ROW_W'($urandom_range(nr - 1));
      rq.column = COL_W'($urandom_range(nc - 1));
      // crowd large grids near the far corner so patterns form there
      if (nr > 8 && nc > 8 && $urandom_range(1) == 0) begin
        rq.row    = ROW_W'($urandom_range(nr - 1, nr - 6));
        rq.column = COL_W'($urandom_range(nc - 1, nc - 6));
      end
    end
    if (roll < 7)       rq.cmd = CMD_STEP;
    else if (roll < 10) rq.cmd = CMD_UNUSED;
    else if (roll < 52) rq.cmd = CMD_WRITE;
    else                rq.cmd = CMD_READ;
    return rq;
  endfunction

  initial begin
    int phase_rows [RANDOM_PHASES];
    int phase_cols [RANDOM_PHASES];
    phase_rows = '{64, 1, 3, 8, 5, 64, 0, 2, 0};
    phase_cols = '{64, 1, 3, 8, 12, 3, 0, 64, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset geometry 40 x 60
    @(negedge clk_i);
    queue_req(CMD_WRITE, 0, 0, 1'b1);
    queue_req(CMD_READ, 0, 0, 1'b0);
    for (int r = 1; r <= 3; r++) begin
      for (int c = 1; c <= 3; c++) begin
        if (r != 2 || c != 2) queue_req(CMD_WRITE, r, c, 1'b1);
      end
    end
    queue_req(CMD_READ, 2, 2, 1'b0);
    queue_req(CMD_READ, 39, 59, 1'b0);
    queue_req(CMD_READ, 40, 0, 1'b0);
    queue_req(CMD_WRITE, 0, 60, 1'b1);
    queue_req(CMD_READ, 63, 63, 1'b0);
    queue_req(CMD_UNUSED, 63, 63, 1'b1);
    queue_req(CMD_STEP, 0, 0, 1'b0);
    queue_req(CMD_READ, 2, 2, 1'b0);
    queue_req(CMD_WRITE, 1, 1, 1'b0);
    queue_req(CMD_STEP, 0, 0, 1'b0);
    drain();

    // zero rows: writes and reads flagged, step clears the grid
    set_grid(0, 64);
    @(negedge clk_i);
    queue_req(CMD_WRITE, 0, 0, 1'b1);
    queue_req(CMD_READ, 0, 0, 1'b0);
    queue_req(CMD_STEP, 0, 0, 1'b0);
    drain();

    // oversized registers act as the full grid
    set_grid(127, 127);
    @(negedge clk_i);
    queue_req(CMD_WRITE, 63, 63, 1'b1);
    queue_req(CMD_WRITE, 63, 62, 1'b1);
    queue_req(CMD_WRITE, 62, 63, 1'b1);
    queue_req(CMD_READ, 63, 63, 1'b0);
    queue_req(CMD_READ, 1, 2, 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 6) begin
        set_grid($urandom_range(127), $urandom_range(127));
      end else if (p == 8) begin
        set_grid($urandom_range(10, 3), $urandom_range(10, 3));
      end else begin
        set_grid(phase_rows[p], phase_cols[p]);
      end
      @(negedge clk_i);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      for (int k = 0; k < PHASE_REQS; k++) req_backlog.push_back(rand_req());
      drain();
    end

    // backpressure: receiver held off while the sender keeps going
    set_grid(6, 6);
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b1;
    for (int k = 0; k < 40; k++) req_backlog.push_back(rand_req());
    drain();

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
